// ===== hw/rtl/kalman_filter_2state_unit_defines.svh =====
// Assertion macros used by the checker file of the two-state Kalman filter.
`ifndef KALMAN_FILTER_2STATE_UNIT_DEFINES_SVH
`define KALMAN_FILTER_2STATE_UNIT_DEFINES_SVH

// Asserts that an antecedent implies a consequent in the same cycle, outside reset.
`define KF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Asserts that an antecedent implies a consequent in the following cycle, outside reset.
`define KF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/kf2_pkg.sv =====
// Package with shared types, constants and an arithmetic helper of the Kalman filter.
package kf2_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned CfgW  = 31;
  localparam int unsigned IdxW  = 2;

  localparam logic [IdxW-1:0] RegTimeStep     = 2'd0;
  localparam logic [IdxW-1:0] RegProcessNoise = 2'd1;
  localparam logic [IdxW-1:0] RegMeasureNoise = 2'd2;

  localparam logic [CfgW-1:0] TimeStepRst     = 31'd0;
  localparam logic [CfgW-1:0] ProcessNoiseRst = 31'd6554;
  localparam logic [CfgW-1:0] MeasureNoiseRst = 31'd20316;

  localparam logic signed [WordW-1:0] SatMax = 32'sh7FFF_FFFF;
  localparam logic signed [WordW-1:0] SatMin = 32'sh8000_0000;

  // Micro-operation codes issued by the controller.
  typedef enum logic [5:0] {
    U_XP0, U_XP1, U_BQ0, U_BQ1, U_PP0, U_PP1, U_PP2, U_PP3,
    U_RDT, U_R00, U_S, U_DET, U_DIV0, U_DIV1, U_DIV2, U_DIV3,
    U_K00, U_K01, U_K10, U_K11, U_E, U_X0, U_X1,
    U_C0, U_C1, U_C2, U_C3, U_NONE
  } uop_t;

  typedef struct packed {
    logic start_div;
    logic load;
    logic clear;
    logic step;
    uop_t uop;
  } kf2_cmd_t;

  typedef struct packed {
    logic div_done;
    logic singular;
  } kf2_sts_t;

  function automatic logic signed [WordW-1:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return SatMax;
    else if (v < -66'sd2147483648) return SatMin;
    else return v[WordW-1:0];
  endfunction

endpackage

// ===== hw/rtl/kf2_if.sv =====
// Valid/ready channel interfaces of the Kalman filter.
interface kf2_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] control_input;
  logic [31:0] meas_first;
  logic [31:0] meas_second;
  modport source (output valid, func, control_input, meas_first, meas_second, input ready);
  modport sink (input valid, func, control_input, meas_first, meas_second, output ready);
endinterface

interface kf2_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] est_first;
  logic [31:0] est_second;
  logic        singular;
  modport source (output valid, est_first, est_second, singular, input ready);
  modport sink (input valid, est_first, est_second, singular, output ready);
endinterface

interface kf2_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [30:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/kf2_div.sv =====
// Restoring divider that forms sat(trunc(num * 2^SH / den)) one bit per cycle.
module kf2_div #(
  parameter int unsigned SH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [32:0]  num,
  input  logic signed [65:0]  den,
  output logic                done,
  output logic signed [31:0]  quo
);
  import kf2_pkg::*;

  localparam int unsigned NB = 33 + SH;
  localparam int unsigned CW = $clog2(NB + 1);

  logic [NB-1:0] rem_num_r, rem_num_nxt;
  logic [65:0]   den_r, den_nxt;
  logic [66:0]   part_r, part_nxt;
  logic [NB-1:0] q_r, q_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          neg_r, neg_nxt;
  logic          done_r, done_nxt;
  logic [66:0]   trial;
  logic [32:0]   un;

  always_comb begin
    un = num[32] ? 33'(-num) : 33'(num);
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_num_nxt = rem_num_r;
    den_nxt = den_r;
    part_nxt = part_r;
    q_nxt = q_r;
    cnt_nxt = cnt_r;
    neg_nxt = neg_r;
    trial = {part_r[65:0], rem_num_r[NB-1]};
    if (start) begin
      busy_nxt = 1'b1;
      rem_num_nxt = {un, {SH{1'b0}}};
      den_nxt = den[65] ? 66'(-den) : 66'(den);
      part_nxt = '0;
      q_nxt = '0;
      cnt_nxt = CW'(NB);
      neg_nxt = num[32] ^ den[65];
    end else if (busy_r) begin
      rem_num_nxt = {rem_num_r[NB-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        part_nxt = trial - {1'b0, den_r};
        q_nxt = {q_r[NB-2:0], 1'b1};
      end else begin
        part_nxt = trial;
        q_nxt = {q_r[NB-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_num_r <= rem_num_nxt;
    den_r <= den_nxt;
    part_r <= part_nxt;
    q_r <= q_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
  end

  always_comb begin
    if (neg_r) begin
      quo = (q_r > NB'(33'h0_8000_0000)) ? SatMin : 32'(-q_r);
    end else begin
      quo = (q_r > NB'(33'h0_7FFF_FFFF)) ? SatMax : q_r[31:0];
    end
  end

  assign done = done_r;

endmodule

// ===== hw/rtl/kf2_datapath.sv =====
// Datapath: state, covariance, scratch registers, shared multipliers and divider.
module kf2_datapath #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  kf2_pkg::kf2_cmd_t      cmd,
  output kf2_pkg::kf2_sts_t      sts,
  input  logic [30:0]            dt_cfg,
  input  logic [30:0]            q_cfg,
  input  logic [30:0]            r_cfg,
  input  logic [31:0]            u_in,
  input  logic [31:0]            z0_in,
  input  logic [31:0]            z1_in,
  output logic [31:0]            x0_out,
  output logic [31:0]            x1_out
);
  import kf2_pkg::*;

  typedef logic signed [31:0] w_t;

  localparam w_t Two = w_t'(64'sd2 <<< FRAC_BITS);

  w_t x0_r, x1_r, c0_r, c1_r, c2_r, c3_r;
  w_t u_r, z0_r, z1_r;
  w_t bq0_r, bq1_r, rdt_r, r00_r, r01_r;
  w_t s00_r, s01_r, s10_r, s11_r;
  w_t i00_r, i01_r, i10_r, i11_r;
  w_t k00_r, k01_r, k10_r, k11_r, e0_r, e1_r;
  logic signed [65:0] det_r;

  w_t dt, q, r;
  logic signed [63:0] pa, pb;
  logic signed [65:0] fa, fb;
  logic signed [63:0] dp0, dp1;
  logic signed [32:0] dnum;
  logic div_done;
  w_t div_q;
  logic [1:0] div_sel_r;

  assign dt = w_t'({1'b0, dt_cfg});
  assign q  = w_t'({1'b0, q_cfg});
  assign r  = w_t'({1'b0, r_cfg});

  // Two multipliers per micro-op feed a dot product; single products use pb = 0.
  always_comb begin
    pa = '0;
    pb = '0;
    case (cmd.uop)
      U_XP0: pa = dt * u_r;
      U_XP1: pa = Two * u_r;
      U_BQ0: pa = dt * q;
      U_BQ1: pa = Two * q;
      U_PP0: pa = bq0_r * dt;
      U_PP1: pa = bq0_r * Two;
      U_PP2: pa = bq1_r * dt;
      U_PP3: pa = bq1_r * Two;
      U_RDT: pa = r * dt;
      U_R00: pa = rdt_r * dt;
      U_K00: begin pa = c0_r * i00_r; pb = c1_r * i10_r; end
      U_K01: begin pa = c0_r * i01_r; pb = c1_r * i11_r; end
      U_K10: begin pa = c2_r * i00_r; pb = c3_r * i10_r; end
      U_K11: begin pa = c2_r * i01_r; pb = c3_r * i11_r; end
      U_X0:  begin pa = k00_r * e0_r; pb = k01_r * e1_r; end
      U_X1:  begin pa = k10_r * e0_r; pb = k11_r * e1_r; end
      U_C0:  begin pa = k00_r * c0_r; pb = k01_r * c2_r; end
      U_C1:  begin pa = k00_r * c1_r; pb = k01_r * c3_r; end
      U_C2:  begin pa = k10_r * c0_r; pb = k11_r * c2_r; end
      U_C3:  begin pa = k10_r * c1_r; pb = k11_r * c3_r; end
      default: begin pa = '0; pb = '0; end
    endcase
    fa = 66'(pa) >>> FRAC_BITS;
    fb = 66'(pb) >>> FRAC_BITS;
  end

  w_t prod, dotv;
  assign prod = sat32(fa);
  assign dotv = sat32(fa + fb);

  assign dp0 = s00_r * s11_r;
  assign dp1 = s01_r * s10_r;

  always_comb begin
    case (div_sel_r)
      2'd0: dnum = 33'(s11_r);
      2'd1: dnum = -33'(s01_r);
      2'd2: dnum = -33'(s10_r);
      default: dnum = 33'(s00_r);
    endcase
  end

  kf2_div #(.SH(2 * FRAC_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.start_div),
    .num   (dnum),
    .den   (det_r),
    .done  (div_done),
    .quo   (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x0_r <= '0; x1_r <= '0;
      c0_r <= '0; c1_r <= '0; c2_r <= '0; c3_r <= '0;
      div_sel_r <= '0;
    end else begin
      if (cmd.load) begin
        u_r <= w_t'(u_in); z0_r <= w_t'(z0_in); z1_r <= w_t'(z1_in);
      end
      if (cmd.clear) begin
        x0_r <= '0; x1_r <= '0;
        c0_r <= '0; c1_r <= '0; c2_r <= '0; c3_r <= '0;
      end else if (cmd.step) begin
        case (cmd.uop)
          U_XP0: x0_r <= prod;
          // The negated state saturates on its own before the drive term is added.
          U_XP1: x1_r <= sat32(66'(sat32(-66'(x1_r))) + 66'(prod));
          U_BQ0: bq0_r <= prod;
          U_BQ1: bq1_r <= prod;
          U_PP0: c0_r <= prod;
          U_PP1: c1_r <= prod;
          U_PP2: c2_r <= prod;
          U_PP3: c3_r <= sat32(66'(c3_r) + 66'(prod));
          U_RDT: begin rdt_r <= prod; r01_r <= prod >>> 1; end
          U_R00: r00_r <= prod >>> 2;
          U_S: begin
            s00_r <= sat32(66'(c0_r) + 66'(r00_r));
            s01_r <= sat32(66'(c1_r) + 66'(r01_r));
            s10_r <= sat32(66'(c2_r) + 66'(r01_r));
            s11_r <= sat32(66'(c3_r) + 66'(r));
          end
          U_DET: begin
            det_r <= 66'(dp0) - 66'(dp1);
            div_sel_r <= 2'd0;
          end
          U_DIV0: begin i00_r <= div_q; div_sel_r <= 2'd1; end
          U_DIV1: begin i01_r <= div_q; div_sel_r <= 2'd2; end
          U_DIV2: begin i10_r <= div_q; div_sel_r <= 2'd3; end
          U_DIV3: i11_r <= div_q;
          U_K00: k00_r <= dotv;
          U_K01: k01_r <= dotv;
          U_K10: k10_r <= dotv;
          U_K11: k11_r <= dotv;
          U_E: begin
            e0_r <= sat32(66'(z0_r) - 66'(x0_r));
            e1_r <= sat32(66'(z1_r) - 66'(x1_r));
          end
          U_X0: x0_r <= sat32(66'(x0_r) + 66'(dotv));
          U_X1: x1_r <= sat32(66'(x1_r) + 66'(dotv));
          U_C0: i00_r <= sat32(66'(c0_r) - 66'(dotv));
          U_C1: i01_r <= sat32(66'(c1_r) - 66'(dotv));
          U_C2: i10_r <= sat32(66'(c2_r) - 66'(dotv));
          U_C3: begin
            // The new covariance is committed at once so every row uses the predicted P.
            c0_r <= i00_r; c1_r <= i01_r; c2_r <= i10_r;
            c3_r <= sat32(66'(c3_r) - 66'(dotv));
          end
          default: ;
        endcase
      end
    end
  end

  assign sts.div_done = div_done;
  assign sts.singular = (det_r == '0);
  assign x0_out = x0_r;
  assign x1_out = x1_r;

endmodule

// ===== hw/rtl/kf2_ctrl.sv =====
// Controller state machine that sequences the filter micro-operations.
module kf2_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_go,
  input  logic              in_func,
  input  logic              out_free,
  input  kf2_pkg::kf2_sts_t sts,
  output kf2_pkg::kf2_cmd_t cmd,
  output logic              in_rdy,
  output logic              res_valid,
  output logic              res_singular
);
  import kf2_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RUN  = 5'b00010,
    S_WDIV = 5'b00100,
    S_DONE = 5'b01000,
    S_HOLD = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  uop_t   uop_r, uop_nxt;
  logic   sing_r, sing_nxt;

  always_comb begin
    state_nxt = state_r;
    uop_nxt = uop_r;
    sing_nxt = sing_r;
    cmd = '{start_div: 1'b0, load: 1'b0, clear: 1'b0, step: 1'b0, uop: uop_r};
    in_rdy = 1'b0;
    res_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_rdy = out_free;
        if (in_go) begin
          cmd.load = 1'b1;
          sing_nxt = 1'b0;
          if (in_func) begin
            cmd.clear = 1'b1;
            state_nxt = S_DONE;
          end else begin
            uop_nxt = U_XP0;
            state_nxt = S_RUN;
          end
        end
      end
      S_RUN: begin
        cmd.step = 1'b1;
        uop_nxt = uop_t'(uop_r + 1'b1);
        case (uop_r)
          U_DET: state_nxt = S_RUN;
          U_DIV0, U_DIV1, U_DIV2, U_DIV3: begin
            if (uop_r == U_DIV3) uop_nxt = U_K00;
            state_nxt = (uop_r == U_DIV3) ? S_RUN : S_WDIV;
          end
          U_C3: state_nxt = S_DONE;
          default: ;
        endcase
        if (uop_r == U_DET) begin
          cmd.step = 1'b1;
          uop_nxt = U_DIV0;
          state_nxt = S_WDIV;
        end
      end
      S_WDIV: begin
        // Unless singular, the divider starts on the new numerator select.
        if (uop_r == U_DIV0 && sts.singular) begin
          sing_nxt = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.start_div = 1'b1;
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        if (sts.div_done) state_nxt = S_RUN;
      end
      S_DONE: begin
        res_valid = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      uop_r <= U_XP0;
      sing_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      uop_r <= uop_nxt;
      sing_r <= sing_nxt;
    end
  end

  assign res_singular = sing_r;

endmodule

// ===== hw/rtl/kalman_filter_2state_unit.sv =====
// Top level of the two-state Kalman filter: config registers, output register, units.
//
//  channel | dir | handshake       | payload
//  in      | in  | in_valid/ready  | func, control_input, meas_first, meas_second
//  out     | out | out_valid/ready | est_first, est_second, singular
//  cfg     | in  | cfg_valid/ready | index, data
//
// The four inverse entries of a filter item are formed one after another by the shared
// bit-serial divider. Reset is synchronous and clears state and covariance.
// A result waits in the output register and no input is taken meanwhile; the next item
// can transfer in the cycle after the result transfer.
module kalman_filter_2state_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  kf2_in_if.sink            in_ch,
  kf2_out_if.source         out_ch,
  kf2_cfg_if.sink           cfg_ch
);
  import kf2_pkg::*;

  logic [CfgW-1:0] dt_r, q_r, r_r;
  kf2_cmd_t cmd;
  kf2_sts_t sts;
  logic in_rdy, res_valid, res_sing;
  logic [31:0] x0, x1;
  logic ov_r;
  logic [31:0] o0_r, o1_r;
  logic os_r;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r <= TimeStepRst;
      q_r <= ProcessNoiseRst;
      r_r <= MeasureNoiseRst;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        RegTimeStep:     dt_r <= cfg_ch.data;
        RegProcessNoise: q_r <= cfg_ch.data;
        RegMeasureNoise: r_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign in_ch.ready = in_rdy;

  kf2_ctrl u_ctrl (
    .clk (clk), .rst_n (rst_n),
    .in_go (in_ch.valid && in_rdy), .in_func (in_ch.func),
    .out_free (!ov_r), .sts (sts), .cmd (cmd),
    .in_rdy (in_rdy), .res_valid (res_valid), .res_singular (res_sing)
  );

  kf2_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk (clk), .rst_n (rst_n), .cmd (cmd), .sts (sts),
    .dt_cfg (dt_r), .q_cfg (q_r), .r_cfg (r_r),
    .u_in (in_ch.control_input), .z0_in (in_ch.meas_first), .z1_in (in_ch.meas_second),
    .x0_out (x0), .x1_out (x1)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (res_valid) begin
      ov_r <= 1'b1;
    end else if (out_ch.ready) begin
      ov_r <= 1'b0;
    end
    if (res_valid) begin
      o0_r <= x0; o1_r <= x1; os_r <= res_sing;
    end
  end

  assign out_ch.valid = ov_r;
  assign out_ch.est_first = o0_r;
  assign out_ch.est_second = o1_r;
  assign out_ch.singular = os_r;

endmodule

// ===== hw/rtl/kf2_checker.sv =====
// Port-level checker for the Kalman filter and its bind statement.
`include "kalman_filter_2state_unit_defines.svh"
module kf2_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_singular,
  input logic [31:0] out_est_first,
  input logic [31:0] out_est_second
);
  `KF_ASSERT_IMPL(a_no_take_busy, clk, rst_n, out_valid && !out_ready, !in_ready, "input taken while result waits")
  `KF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_est_first) && $stable(out_est_second) && $stable(out_singular), "result dropped")
  `KF_ASSERT_NEXT(a_one_result, clk, rst_n, in_valid && in_ready, !out_valid, "result too early")
endmodule

bind kalman_filter_2state_unit kf2_checker u_kf2_checker (
  .clk (clk), .rst_n (rst_n),
  .in_valid (in_ch.valid), .in_ready (in_ch.ready),
  .out_valid (out_ch.valid), .out_ready (out_ch.ready),
  .out_singular (out_ch.singular),
  .out_est_first (out_ch.est_first), .out_est_second (out_ch.est_second)
);
